@@ src/ordered_array_list_engine_unit_assert.svh @@
// Assertion macros shared by the list engine RTL.
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/oale_pkg.sv @@
// Shared types and codes for the ordered array list engine.
package oale_pkg;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_DELETE = 3'd1;
  localparam logic [2:0] MODE_GET    = 3'd2;
  localparam logic [2:0] MODE_LOCATE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // Broadcast controls for every cell of the chain.
  typedef struct packed {
    logic scan;        // pass the first-hit record one cell along
    logic find;        // hit on value match instead of position
    logic shift_up;    // insert commit: open a slot at the position
    logic shift_down;  // delete commit: close the slot at the position
  } cell_ctl_t;

endpackage

@@ src/oale_cell.sv @@
// One list slot: holds an entry, shifts with its neighbors, forwards the first hit.
module oale_cell import oale_pkg::*; #(
  parameter int IDX = 0,
  parameter int EW  = 32,
  parameter int NW  = 7
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [NW-1:0] pos,
  input  logic [NW-1:0] cnt,
  input  logic [EW-1:0] val,
  input  logic [EW-1:0] left_data,
  input  logic [EW-1:0] right_data,
  output logic [EW-1:0] data,
  input  logic          left_found,
  input  logic [EW-1:0] left_elem,
  input  logic [NW-1:0] left_pos,
  output logic          acc_found,
  output logic [EW-1:0] acc_elem,
  output logic [NW-1:0] acc_pos
);

  localparam logic [NW-1:0] MYPOS = NW'(IDX + 1);

  logic [EW-1:0] data_r, data_nxt;
  logic          acc_found_r, acc_found_nxt;
  logic [EW-1:0] acc_elem_r, acc_elem_nxt;
  logic [NW-1:0] acc_pos_r, acc_pos_nxt;
  logic          hit;

  always_comb begin
    priority if (ctl.shift_up && (pos == MYPOS)) begin
      data_nxt = val;
    end else if (ctl.shift_up && (pos < MYPOS)) begin
      data_nxt = left_data;
    end else if (ctl.shift_down && (pos <= MYPOS)) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  assign hit = ctl.find ? ((data_r == val) && (MYPOS <= cnt)) : (pos == MYPOS);

  // earlier hit wins; a cell with no hit upstream offers its own
  always_comb begin
    if (!ctl.scan) begin
      acc_found_nxt = acc_found_r;
      acc_elem_nxt  = acc_elem_r;
      acc_pos_nxt   = acc_pos_r;
    end else if (left_found) begin
      acc_found_nxt = 1'b1;
      acc_elem_nxt  = left_elem;
      acc_pos_nxt   = left_pos;
    end else begin
      acc_found_nxt = hit;
      acc_elem_nxt  = data_r;
      acc_pos_nxt   = MYPOS;
    end
  end

  always_ff @(posedge clk) begin
    data_r      <= data_nxt;
    acc_found_r <= acc_found_nxt;
    acc_elem_r  <= acc_elem_nxt;
    acc_pos_r   <= acc_pos_nxt;
  end

  assign data      = data_r;
  assign acc_found = acc_found_r;
  assign acc_elem  = acc_elem_r;
  assign acc_pos   = acc_pos_r;

endmodule

@@ src/ordered_array_list_engine_unit.sv @@
// Top level of the ordered array list engine: control, cell chain and result register.
//
// Usage:
//   in_*  : one request beat (mode, position, value), valid/ready.
//   out_* : one result beat per request (ok, element, found_at, count), valid/ready.
// The list lives in a chain of DEPTH cells, one entry per cell. Insert and delete
// shift the cells from the position on by one slot, all at the commit.
// Get, delete and locate send a first-hit record down the chain, one cell per
// cycle, so the record from the last cell is final when the scan state ends.
// After acceptance, insert, clear and unknown modes go straight to the apply
// state; delete, get and locate walk the chain in the scan state first. The
// result is registered at commit, which needs the output register free.
// One request is in flight at a time; in_ready is high only when idle. A new
// request may be taken while the previous result still waits in the output
// register; it then holds in its commit cycle until that result is taken.
// A new request is taken only after the previous one commits; reads also walk
// the chain first, and a stalled receiver delays the commit.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// stored entries are not cleared.
module ordered_array_list_engine_unit import oale_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic signed [31:0] out_element,
  output logic [5:0]         out_found_at,
  output logic [5:0]         out_count
);

  localparam int CW = $clog2(DEPTH + 1);            // holds 0..DEPTH
  localparam int NW = ((CW > 6) ? CW : 6) + 1;      // room for count + 1 and any position
  localparam int SW = $clog2(DEPTH);
  localparam logic [SW-1:0] SCAN_LAST = SW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

  state_t state_r, state_nxt;
  logic [SW-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [2:0]            mode_r;
  logic [5:0]            pos_r;
  logic [ELEM_WIDTH-1:0] val_r, val_in;

  logic                  out_valid_r;
  logic                  out_ok_r, ok_nxt;
  logic [31:0]           out_elem_r, elem_nxt;
  logic [5:0]            out_found_r, found_nxt;
  logic [5:0]            out_count_r;

  logic                  commit;
  logic                  ins_ok, rd_ok;
  logic [NW-1:0]         pos_w, cnt_w;
  logic [31:0]           elem32;
  cell_ctl_t             ctl;

  logic [ELEM_WIDTH-1:0] cell_data  [DEPTH];
  logic [ELEM_WIDTH-1:0] left_w     [DEPTH];
  logic [ELEM_WIDTH-1:0] right_w    [DEPTH];
  logic                  chain_found[DEPTH+1];
  logic [ELEM_WIDTH-1:0] chain_elem [DEPTH+1];
  logic [NW-1:0]         chain_pos  [DEPTH+1];

  // value field into element width
  if (ELEM_WIDTH <= 32) begin : g_val_narrow
    assign val_in = in_value[ELEM_WIDTH-1:0];
  end else begin : g_val_wide
    assign val_in = {{(ELEM_WIDTH-32){in_value[31]}}, in_value};
  end

  // element back out to 32 bits, sign extended when narrower
  if (ELEM_WIDTH >= 32) begin : g_out_narrow
    assign elem32 = chain_elem[DEPTH][31:0];
  end else begin : g_out_wide
    assign elem32 = {{(32-ELEM_WIDTH){chain_elem[DEPTH][ELEM_WIDTH-1]}}, chain_elem[DEPTH]};
  end

  assign pos_w  = NW'(pos_r);
  assign cnt_w  = NW'(count_r);
  assign ins_ok = (count_r < CNT_FULL) && (pos_r != 6'd0) && (pos_w <= cnt_w + NW'(1));
  assign rd_ok  = (pos_r != 6'd0) && (pos_w <= cnt_w);
  assign commit = (state_r == ST_APPLY) && (!out_valid_r || out_ready);

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if ((in_mode == MODE_DELETE) || (in_mode == MODE_GET) ||
              (in_mode == MODE_LOCATE)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == SCAN_LAST) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    ctl.scan       = (state_r == ST_SCAN);
    ctl.find       = (mode_r == MODE_LOCATE);
    ctl.shift_up   = commit && (mode_r == MODE_INSERT) && ins_ok;
    ctl.shift_down = commit && (mode_r == MODE_DELETE) && rd_ok;
    scan_cnt_nxt   = (state_r == ST_SCAN) ? scan_cnt_r + SW'(1) : '0;
  end

  // result and new length for the request being committed
  always_comb begin
    ok_nxt    = 1'b0;
    elem_nxt  = '0;
    found_nxt = '0;
    count_nxt = count_r;
    unique case (mode_r)
      MODE_INSERT: begin
        ok_nxt = ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_DELETE: begin
        ok_nxt = rd_ok;
        if (rd_ok) begin
          elem_nxt  = elem32;
          count_nxt = count_r - CW'(1);
        end
      end
      MODE_GET: begin
        ok_nxt = rd_ok;
        if (rd_ok) begin
          elem_nxt = elem32;
        end
      end
      MODE_LOCATE: begin
        ok_nxt = chain_found[DEPTH];
        if (chain_found[DEPTH]) begin
          found_nxt = 6'(chain_pos[DEPTH]);
        end
      end
      MODE_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= val_in;
    end
    if (commit) begin
      out_ok_r    <= ok_nxt;
      out_elem_r  <= elem_nxt;
      out_found_r <= found_nxt;
      out_count_r <= 6'(count_nxt);
    end
  end

  // ---------------- cell chain ----------------
  assign chain_found[0] = 1'b0;
  assign chain_elem[0]  = '0;
  assign chain_pos[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid
      assign left_w[i] = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w[i] = cell_data[i];
    end else begin : g_inner
      assign right_w[i] = cell_data[i+1];
    end

    oale_cell #(
      .IDX (i),
      .EW  (ELEM_WIDTH),
      .NW  (NW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos_w),
      .cnt        (cnt_w),
      .val        (val_r),
      .left_data  (left_w[i]),
      .right_data (right_w[i]),
      .data       (cell_data[i]),
      .left_found (chain_found[i]),
      .left_elem  (chain_elem[i]),
      .left_pos   (chain_pos[i]),
      .acc_found  (chain_found[i+1]),
      .acc_elem   (chain_elem[i+1]),
      .acc_pos    (chain_pos[i+1])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_element  = out_elem_r;
  assign out_found_at = out_found_r;
  assign out_count    = out_count_r;

  // ---------------- checks ----------------
`include "ordered_array_list_engine_unit_assert.svh"

  `OALE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_FULL, "list length beyond depth")
  `OALE_ASSERT_NEXT(a_ins_len, ctl.shift_up, count_r == $past(count_r) + CW'(1), "insert length")
  `OALE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken")
  `OALE_ASSERT_NOW(a_locate_pos, commit && (mode_r == MODE_LOCATE) && chain_found[DEPTH],
                   (chain_pos[DEPTH] != '0) && (chain_pos[DEPTH] <= cnt_w), "locate position")

endmodule
